// ===== rtl/core/dtt_pkg.sv =====
// Shared types and constants for the deadline timer table.
`timescale 1ns / 1ps
package dtt_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned WAIT_W   = 24;
  localparam int unsigned IN_ID_W  = 8;
  localparam int unsigned OUT_ID_W = 8;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [TIME_W-1:0] TIME_NONE = '1;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_COLLECT = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_QUERY   = 2'd3
  } dtt_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL
  } dtt_state_t;

  typedef enum logic [1:0] {
    RES_START,
    RES_QUERY,
    RES_PEND,
    RES_EMPTY
  } dtt_res_t;

  // controller -> datapath
  typedef struct packed {
    logic     take;
    logic     scan;
    logic     emit;
    dtt_res_t res;
    logic     last;
    logic     arm_new;
    logic     rel_best;
    logic     close;
  } dtt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic    scan_done;
    dtt_op_t op;
    logic    owner_match;
    logic    free_avail;
    logic    rel_ok;
    logic    pend_valid;
    logic    out_free;
  } dtt_stat_t;

endpackage

// ===== rtl/core/dtt_ctrl.sv =====
// Controller state machine for the deadline timer table.
`timescale 1ns / 1ps
module dtt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  dtt_pkg::dtt_stat_t stat,
  output dtt_pkg::dtt_cmd_t  cmd
);
  import dtt_pkg::*;

  dtt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_done) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (stat.out_free) begin
          if ((stat.op inside {CMD_COLLECT, CMD_CLEAR}) && stat.rel_ok) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
        cmd.scan  = in_tvalid;
      end
      ST_EVAL: begin
        if (stat.out_free) begin
          case (stat.op)
            CMD_START: begin
              cmd.emit    = 1'b1;
              cmd.res     = RES_START;
              cmd.last    = 1'b1;
              cmd.arm_new = !stat.owner_match && stat.free_avail;
            end
            CMD_QUERY: begin
              cmd.emit = 1'b1;
              cmd.res  = RES_QUERY;
              cmd.last = 1'b1;
            end
            default: begin
              // a release is held back one scan so its last flag is known
              if (stat.pend_valid) begin
                cmd.emit = 1'b1;
                cmd.res  = RES_PEND;
                cmd.last = !stat.rel_ok;
              end else if (!stat.rel_ok) begin
                cmd.emit = 1'b1;
                cmd.res  = RES_EMPTY;
                cmd.last = 1'b1;
              end
              if (stat.rel_ok) begin
                cmd.rel_best = 1'b1;
                cmd.scan     = 1'b1;
              end else begin
                cmd.close = 1'b1;
              end
            end
          endcase
        end
      end
      default: begin
        cmd       = '0;
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/dtt_dp.sv =====
// Datapath: entry memory, table scan, timer state and result register.
`timescale 1ns / 1ps
module dtt_dp #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [dtt_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic [1:0]                          in_tuser,
  input  dtt_pkg::dtt_cmd_t                   cmd,
  output dtt_pkg::dtt_stat_t                  stat,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dtt_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast,
  output logic [0:0]                          out_tuser
);
  import dtt_pkg::*;

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CW    = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENT_W = ID_BITS + 2 * TIME_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // item registers
  dtt_op_t             op_r;
  logic [ID_BITS-1:0]  id_r;
  logic [WAIT_W-1:0]   wait_r;
  logic [TIME_W-1:0]   now_r;
  logic [IN_ID_W+ID_BITS-1:0] id_ext;

  // entry memory: {owner, deadline, order}
  logic [ENT_W-1:0]    mem [TABLE_DEPTH];
  logic [ENT_W-1:0]    rd_data_r;
  logic [TABLE_DEPTH-1:0] valid_r;

  // scan control
  logic [CW-1:0]       idx_r;
  logic                busy_r;
  logic                rd_vld_r;
  logic [AW-1:0]       rd_idx_r;
  logic                issue;
  logic                scan_done;

  // scan results
  logic                match_r;
  logic                found_r;
  logic [AW-1:0]       best_idx_r;
  logic [TIME_W-1:0]   best_dl_r;
  logic [TIME_W-1:0]   best_ord_r;
  logic [ID_BITS-1:0]  best_owner_r;

  logic [ID_BITS-1:0]  e_owner;
  logic [TIME_W-1:0]   e_dl;
  logic [TIME_W-1:0]   e_ord;
  logic                e_valid;
  logic                better;

  // timer state
  logic [TIME_W-1:0]   cnt_r;
  logic [TIME_W-1:0]   earliest_r;
  logic                pend_valid_r;
  logic [ID_BITS-1:0]  pend_id_r;
  logic [ID_BITS+OUT_ID_W-1:0] pend_ext;

  logic [TIME_W:0]     dl_sum;
  logic [TIME_W-1:0]   dl_new;
  logic [TIME_W-1:0]   early_arm;
  logic                free_avail;
  logic [AW-1:0]       free_idx;
  logic                rel_ok;

  // result register
  logic                out_valid_r;
  logic                o_has_r, o_last_r, o_acc_r, o_arm_r, o_ready_r;
  logic [OUT_ID_W-1:0] o_id_r;
  logic                r_has, r_acc, r_arm, r_ready;
  logic [OUT_ID_W-1:0] r_id;
  logic                out_free;

  assign id_ext = {{ID_BITS{1'b0}}, in_tdata[IN_ID_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r   <= dtt_op_t'(in_tuser);
      id_r   <= id_ext[ID_BITS-1:0];
      wait_r <= in_tdata[IN_ID_W +: WAIT_W];
      now_r  <= in_tdata[IN_ID_W+WAIT_W +: TIME_W];
    end
  end

  // saturating deadline
  assign dl_sum = {1'b0, now_r} + {{(TIME_W+1-WAIT_W){1'b0}}, wait_r};
  assign dl_new = dl_sum[TIME_W] ? TIME_NONE : dl_sum[TIME_W-1:0];

  always_comb begin
    free_avail = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_avail = 1'b1;
        free_idx   = AW'(i);
      end
    end
  end

  // scan: one entry read a cycle, data in the cycle after
  assign issue     = busy_r && (idx_r != DEPTH_C);
  assign scan_done = busy_r && (idx_r == DEPTH_C) && !rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      rd_vld_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      rd_vld_r <= issue;
      if (cmd.scan) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else begin
        if (issue) idx_r <= idx_r + 1'b1;
        if (scan_done) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= idx_r[AW-1:0];
    rd_data_r <= mem[idx_r[AW-1:0]];
    if (cmd.arm_new) begin
      mem[free_idx] <= {id_r, dl_new, cnt_r};
    end
  end

  assign e_owner = rd_data_r[ENT_W-1 -: ID_BITS];
  assign e_dl    = rd_data_r[2*TIME_W-1:TIME_W];
  assign e_ord   = rd_data_r[TIME_W-1:0];
  assign e_valid = rd_vld_r && valid_r[rd_idx_r];
  // smallest (deadline, start order) wins
  assign better  = e_valid && (!found_r || (e_dl < best_dl_r) ||
                   ((e_dl == best_dl_r) && (e_ord < best_ord_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
      found_r <= 1'b0;
    end else if (cmd.scan) begin
      match_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (e_valid && (e_owner == id_r)) match_r <= 1'b1;
      if (better) found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      best_idx_r   <= rd_idx_r;
      best_dl_r    <= e_dl;
      best_ord_r   <= e_ord;
      best_owner_r <= e_owner;
    end
  end

  assign rel_ok = found_r && ((op_r == CMD_CLEAR) || (best_dl_r <= now_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      cnt_r        <= '0;
      earliest_r   <= TIME_NONE;
      pend_valid_r <= 1'b0;
    end else begin
      if (cmd.arm_new) begin
        valid_r[free_idx] <= 1'b1;
        cnt_r             <= cnt_r + 1'b1;
        earliest_r        <= early_arm;
      end
      if (cmd.rel_best) begin
        valid_r[best_idx_r] <= 1'b0;
        pend_valid_r        <= 1'b1;
      end else if (cmd.close) begin
        pend_valid_r <= 1'b0;
        // first entry left after a collect, none after a clear
        earliest_r   <= found_r ? best_dl_r : TIME_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rel_best) pend_id_r <= best_owner_r;
  end

  assign early_arm = (cmd.arm_new && (dl_new < earliest_r)) ? dl_new : earliest_r;
  assign pend_ext  = {{OUT_ID_W{1'b0}}, pend_id_r};

  always_comb begin
    r_has   = 1'b0;
    r_id    = '0;
    r_acc   = 1'b0;
    r_arm   = 1'b0;
    r_ready = 1'b0;
    case (cmd.res)
      RES_START: begin
        r_acc   = match_r || free_avail;
        r_arm   = match_r || free_avail;
        r_ready = early_arm < now_r;
      end
      RES_QUERY: begin
        r_arm   = match_r;
        r_ready = earliest_r < now_r;
      end
      RES_PEND: begin
        r_has = 1'b1;
        r_id  = pend_ext[OUT_ID_W-1:0];
      end
      default: begin
        r_has = 1'b0;
      end
    endcase
  end

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_has_r   <= r_has;
      o_id_r    <= r_id;
      o_last_r  <= cmd.last;
      o_acc_r   <= r_acc;
      o_arm_r   <= r_arm;
      o_ready_r <= r_ready;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-OUT_ID_W-3){1'b0}}, o_ready_r, o_arm_r, o_acc_r, o_id_r};
  assign out_tlast  = o_last_r;
  assign out_tuser  = o_has_r;

  always_comb begin
    stat             = '0;
    stat.scan_done   = scan_done;
    stat.op          = op_r;
    stat.owner_match = match_r;
    stat.free_avail  = free_avail;
    stat.rel_ok      = rel_ok;
    stat.pend_valid  = pend_valid_r;
    stat.out_free    = out_free;
  end

endmodule

// ===== rtl/core/deadline_timer_table_core.sv =====
// Top level of the deadline timer table: controller plus datapath, one request at a time.
// Scan: every table entry in turn, then an evaluate state that waits on a full output register.
// Start, query: one scan, then the result is registered in the evaluate state and the controller
//   returns to idle before it takes the next request.
// Collect, clear all with n owners released: n + 1 scans.
// Reset (synchronous, rst_n low) clears all valid bits, start order and earliest deadline.
`timescale 1ns / 1ps
module deadline_timer_table_core #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [dtt_pkg::IN_DATA_W-1:0]  in_tdata,   // owner_id[7:0], wait_ms[31:8], now_ms[63:32]
  input  logic [1:0]                     in_tuser,   // cmd[1:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [dtt_pkg::OUT_DATA_W-1:0] out_tdata,  // released_id[7:0], accepted[8], armed[9],
                                                     // any_ready[10], zero[15:11]
  output logic                           out_tlast,  // last_of_run
  output logic [0:0]                     out_tuser   // has_owner[0]
);
  import dtt_pkg::*;

  dtt_cmd_t  cmd;
  dtt_stat_t stat;

  dtt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dtt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  a_arm_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.arm_new |-> (stat.free_avail && !stat.owner_match))
    else $error("arming without a free slot or with owner already armed");

  a_rel_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rel_best |-> (stat.rel_ok && !cmd.arm_new))
    else $error("release of an entry that is not due");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("new request taken while one is in flight");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !stat.pend_valid)
    else $error("held release left behind at idle");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for deadline_timer_table_core: directed and random timer requests.
`timescale 1ns / 1ps
module tb;
  import dtt_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned TAIL_WAIT  = 2 * (DEPTH + 4);

  typedef struct packed {
    logic       has_owner;
    logic [7:0] released_id;
    logic       last;
    logic       accepted;
    logic       armed;
    logic       any_ready;
  } timer_outcome_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // owner_id[7:0], wait_ms[31:8], now_ms[63:32]
  logic [1:0]            in_tuser = '0;   // cmd[1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // released_id[7:0], accepted[8], armed[9],
                                          // any_ready[10], zero[15:11]
  logic                  out_tlast;       // last_of_run
  logic [0:0]            out_tuser;       // has_owner[0]

  deadline_timer_table_core #(
    .TABLE_DEPTH(DEPTH),
    .ID_BITS    (8)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // Timer table mirror
  logic        tbl_valid    [DEPTH];
  logic [7:0]  tbl_owner    [DEPTH];
  logic [31:0] tbl_deadline [DEPTH];
  logic [31:0] tbl_order    [DEPTH];
  logic [31:0] start_seq;
  logic [31:0] soonest;

  timer_outcome_t outcome_q[$];

  int err_count     = 0;
  int request_count = 0;
  int result_count  = 0;
  int release_count = 0;
  int refused_count = 0;
  int sat_count     = 0;
  int burst_left    = 0;
  int idle_cycles   = 0;

  logic [31:0] rx_cycle = '0;
  logic [1:0]  rx_mode  = '0;

  task automatic table_reset();
    for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
    start_seq = '0;
    soonest   = TIME_NONE;
  endtask

  function automatic int find_owner(input logic [7:0] id);
    for (int i = 0; i < DEPTH; i++)
      if (tbl_valid[i] && tbl_owner[i] == id) return i;
    return -1;
  endfunction

  // earliest (deadline, start order) among armed entries
  function automatic int first_due();
    int best;
    best = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (tbl_valid[i]) begin
        if (best < 0 || tbl_deadline[i] < tbl_deadline[best] ||
            (tbl_deadline[i] == tbl_deadline[best] && tbl_order[i] < tbl_order[best]))
          best = i;
      end
    end
    return best;
  endfunction

  task automatic table_apply(input dtt_op_t cmd, input logic [7:0] id,
                             input logic [23:0] wait_v, input logic [31:0] now);
    timer_outcome_t batch[$];
    timer_outcome_t o;
    int             slot;
    int             f;
    logic [32:0]    sum;
    logic           done;
    logic           ready;
    o = '0;
    case (cmd)
      CMD_START: begin
        o.accepted = 1'b1;
        o.armed    = 1'b1;
        if (find_owner(id) < 0) begin
          slot = -1;
          for (int i = DEPTH - 1; i >= 0; i--)
            if (!tbl_valid[i]) slot = i;
          if (slot < 0) begin
            o.accepted = 1'b0;
            o.armed    = 1'b0;
            refused_count++;
          end else begin
            sum = {1'b0, now} + {9'b0, wait_v};
            if (sum[32]) sat_count++;
            tbl_valid[slot]    = 1'b1;
            tbl_owner[slot]    = id;
            tbl_deadline[slot] = sum[32] ? TIME_NONE : sum[31:0];
            tbl_order[slot]    = start_seq;
            start_seq          = start_seq + 1;
          end
        end
        batch = {batch, o};
      end
      CMD_QUERY: begin
        o.armed = (find_owner(id) >= 0);
        batch = {batch, o};
      end
      default: begin
        done = 1'b0;
        while (!done) begin
          f = first_due();
          if (f < 0 || (cmd == CMD_COLLECT && tbl_deadline[f] > now)) begin
            done = 1'b1;
          end else begin
            tbl_valid[f]  = 1'b0;
            o.has_owner   = 1'b1;
            o.released_id = tbl_owner[f];
            batch = {batch, o};
            release_count++;
          end
        end
        if (batch.size() == 0) batch = {batch, o};
      end
    endcase
    f = first_due();
    soonest = (f < 0) ? TIME_NONE : tbl_deadline[f];
    ready = (soonest < now);
    foreach (batch[k]) begin
      batch[k].any_ready = ready;
      batch[k].last      = (k == batch.size() - 1);
      outcome_q = {outcome_q, batch[k]};
    end
  endtask

  // valid stays high across a burst; it only drops for a gap
  task automatic send_request(input dtt_op_t cmd, input logic [7:0] id,
                              input logic [23:0] wait_v, input logic [31:0] now);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {now, wait_v, id};
    in_tuser  <= cmd;
    do @(posedge clk); while (in_tready !== 1'b1);
    table_apply(cmd, id, wait_v, now);
    request_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic test_edge_values();
    send_request(CMD_COLLECT, 8'h00, 24'h000000, 32'h00000000);  // nothing to release
    send_request(CMD_CLEAR,   8'hFF, 24'hFFFFFF, 32'hFFFFFFFF);
    send_request(CMD_QUERY,   8'hFF, 24'h000000, TIME_NONE);     // empty table, not ready
    send_request(CMD_START,   8'h00, 24'h000000, 32'h00000000);
    send_request(CMD_START,   8'hFF, 24'hFFFFFF, 32'hFFFFFFF0);  // deadline saturates
    send_request(CMD_START,   8'h01, 24'h000000, 32'h00000000);  // ties with owner 0
    send_request(CMD_START,   8'h00, 24'h000005, 32'h00000010);  // already armed
    send_request(CMD_QUERY,   8'h01, 24'h000000, 32'h00000005);
    send_request(CMD_QUERY,   8'h07, 24'h000000, 32'h00000005);
    send_request(CMD_COLLECT, 8'h00, 24'h000000, 32'h00000001);
    send_request(CMD_COLLECT, 8'h00, 24'h000000, 32'hFFFFFFFE);
    send_request(CMD_COLLECT, 8'h00, 24'h000000, TIME_NONE);     // saturated entry goes
  endtask

  task automatic test_full_table();
    for (int k = 0; k < DEPTH; k++)
      send_request(CMD_START, 8'(k * 17), 24'(k * 24'h111111), 32'(k) * 32'h11111111);
    send_request(CMD_START, 8'h77, 24'h000010, 32'h00000100);  // already armed, still accepted
    send_request(CMD_START, 8'h11, 24'h000010, 32'h00000100);  // armed, still accepted
    send_request(CMD_QUERY, 8'h77, 24'h000000, 32'h80000000);
    send_request(CMD_CLEAR, 8'h00, 24'h000000, 32'h80000000);
    wait_all_results();
  endtask

  task automatic test_random_traffic(input int count);
    logic [31:0] cur_now;
    logic [31:0] now;
    logic [23:0] wait_v;
    logic [7:0]  id;
    dtt_op_t     cmd;
    int          pick;
    cur_now = $urandom_range(0, 1000);
    for (int k = 0; k < count; k++) begin
      if (k % 100 == 99) cur_now = $urandom;
      if (k % 150 == 75) wait_all_results();
      pick = $urandom_range(0, 99);
      if (pick < 42)      cmd = CMD_START;
      else if (pick < 72) cmd = CMD_COLLECT;
      else if (pick < 76) cmd = CMD_CLEAR;
      else                cmd = CMD_QUERY;
      if ($urandom_range(0, 9) == 0) begin
        now = $urandom;
      end else begin
        now = cur_now;
        cur_now = cur_now + $urandom_range(0, 400);
      end
      id     = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 23)) : 8'($urandom);
      wait_v = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 3000));
      send_request(cmd, id, wait_v, now);
    end
  endtask

  // receiver: ready pattern picked at random whenever the low seven bits of rx_cycle are zero
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle[6:0] == 7'd0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= 1'($urandom_range(0, 1));
      2'd2:    out_tready <= (rx_cycle[1:0] == 2'd0);
      default: out_tready <= ~rx_cycle[4];
    endcase
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    timer_outcome_t w;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (outcome_q.size() == 0) begin
        $error("result with no request pending");
        err_count++;
      end else begin
        w = outcome_q.pop_front();
        check_field("has_owner",   32'(w.has_owner),   32'(out_tuser[0]));
        check_field("released_id", 32'(w.released_id), 32'(out_tdata[7:0]));
        check_field("accepted",    32'(w.accepted),    32'(out_tdata[8]));
        check_field("armed",       32'(w.armed),       32'(out_tdata[9]));
        check_field("any_ready",   32'(w.any_ready),   32'(out_tdata[10]));
        check_field("pad",         32'd0,              32'(out_tdata[15:11]));
        check_field("last_of_run", 32'(w.last),        32'(out_tlast));
        result_count++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    table_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_values();
    test_full_table();
    test_random_traffic(430);
    in_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    $display("%0d requests, %0d results checked", request_count, result_count);
    $display("%0d owners released, %0d starts refused when full, %0d saturated deadlines",
             release_count, refused_count, sat_count);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/dtt_pkg.sv
rtl/core/dtt_ctrl.sv
rtl/core/dtt_dp.sv
rtl/core/deadline_timer_table_core.sv
tb/sv/tb.sv
